/* rtl/dsps_pkg.sv */
`timescale 1ns / 1ps
package dsps_pkg;

  localparam int SLOT_COUNT_DEF = 8;

  localparam logic [7:0] INST_FORWARD = 8'h40;
  localparam logic [7:0] INST_REVERSE = 8'h60;
  localparam logic [7:0] MAX_STEP     = 8'd28;
  localparam logic [7:0] STOP_INST    = 8'h41;
  localparam logic [7:0] ADDR_MASK    = 8'h7f;

  typedef enum logic [1:0] {
    FUNC_SET_SPEED = 2'd0,
    FUNC_STOP_CTRL = 2'd1,
    FUNC_UPDATE    = 2'd2
  } func_t;

  // 28-step speed code for a saturated step (0..28)
  function automatic logic [7:0] step_code(input logic [4:0] s);
    logic [7:0] c;
    c = 8'h00;
    case (s)
      5'd1:  c = 8'h02;
      5'd2:  c = 8'h12;
      5'd3:  c = 8'h03;
      5'd4:  c = 8'h13;
      5'd5:  c = 8'h04;
      5'd6:  c = 8'h14;
      5'd7:  c = 8'h05;
      5'd8:  c = 8'h15;
      5'd9:  c = 8'h06;
      5'd10: c = 8'h16;
      5'd11: c = 8'h07;
      5'd12: c = 8'h17;
      5'd13: c = 8'h08;
      5'd14: c = 8'h18;
      5'd15: c = 8'h09;
      5'd16: c = 8'h19;
      5'd17: c = 8'h0a;
      5'd18: c = 8'h1a;
      5'd19: c = 8'h0b;
      5'd20: c = 8'h1b;
      5'd21: c = 8'h0c;
      5'd22: c = 8'h1c;
      5'd23: c = 8'h0d;
      5'd24: c = 8'h1d;
      5'd25: c = 8'h0e;
      5'd26: c = 8'h1e;
      5'd27: c = 8'h0f;
      5'd28: c = 8'h1f;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/dsps_slot_ram.sv */
`timescale 1ns / 1ps
module dsps_slot_ram #(
  parameter int DEPTH = dsps_pkg::SLOT_COUNT_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/dsps_emitter.sv */
`timescale 1ns / 1ps
module dsps_emitter #(
  parameter int SLOT_COUNT = dsps_pkg::SLOT_COUNT_DEF,
  parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic                  stopped,
  input  logic [SLOT_COUNT-1:0] valid,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  logic [7:0]            rd_data,
  output logic                  busy,
  output logic                  strobe,
  output logic [7:0]            packet_byte,
  output logic [2:0]            slot_index,
  output logic                  last_of_frame,
  output logic                  last_of_run
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_INST,
    S_CHK,
    S_STOP1,
    S_STOP2
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic [7:0]       inst_q;

  logic             first_found;
  logic [IDX_W-1:0] first_idx;
  logic             next_found;
  logic [IDX_W-1:0] next_idx;
  logic [7:0]       first_wide;
  logic [7:0]       idx_wide;
  logic [7:0]       first_addr;
  logic [7:0]       idx_addr;

  // lowest filled slot overall, and lowest filled slot above the current one
  always_comb begin
    first_found = 1'b0;
    first_idx   = '0;
    next_found  = 1'b0;
    next_idx    = '0;
    for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
      if (valid[j]) begin
        first_found = 1'b1;
        first_idx   = IDX_W'(j);
        if (j > int'(idx)) begin
          next_found = 1'b1;
          next_idx   = IDX_W'(j);
        end
      end
    end
  end

  assign first_wide = 8'(first_idx);
  assign idx_wide   = 8'(idx);
  assign first_addr = (first_wide + 8'd1) & dsps_pkg::ADDR_MASK;
  assign idx_addr   = (idx_wide + 8'd1) & dsps_pkg::ADDR_MASK;

  assign busy    = (state != S_IDLE);
  assign rd_en   = ((state == S_IDLE) && go && !stopped && first_found) || (state == S_ADDR);
  assign rd_addr = (state == S_IDLE) ? first_idx : idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            if (stopped) begin
              strobe        <= 1'b1;
              packet_byte   <= 8'h00;
              slot_index    <= 3'd0;
              last_of_frame <= 1'b0;
              last_of_run   <= 1'b0;
              state         <= S_STOP1;
            end else if (first_found) begin
              strobe        <= 1'b1;
              packet_byte   <= first_addr;
              slot_index    <= first_wide[2:0];
              last_of_frame <= 1'b0;
              last_of_run   <= 1'b0;
              idx           <= first_idx;
              state         <= S_INST;
            end
          end
        end
        S_ADDR: begin
          strobe        <= 1'b1;
          packet_byte   <= idx_addr;
          slot_index    <= idx_wide[2:0];
          last_of_frame <= 1'b0;
          last_of_run   <= 1'b0;
          state         <= S_INST;
        end
        S_INST: begin
          strobe      <= 1'b1;
          packet_byte <= rd_data;
          inst_q      <= rd_data;
          state       <= S_CHK;
        end
        S_CHK: begin
          strobe        <= 1'b1;
          packet_byte   <= idx_addr ^ inst_q;
          last_of_frame <= 1'b1;
          last_of_run   <= !next_found;
          if (next_found) begin
            idx   <= next_idx;
            state <= S_ADDR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_STOP1: begin
          strobe      <= 1'b1;
          packet_byte <= dsps_pkg::STOP_INST;
          state       <= S_STOP2;
        end
        S_STOP2: begin
          strobe        <= 1'b1;
          packet_byte   <= dsps_pkg::STOP_INST;
          last_of_frame <= 1'b1;
          last_of_run   <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/dcc_speed_packet_scheduler_core.sv */
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// command   start / busy       func, loco_address, speed_step, forward, stop_enable
// result    strobe (per byte)  packet_byte, slot_index, last_of_frame, last_of_run
//
// A command beat is taken when start is high and busy is low.
// Set speed and stop control emit nothing and leave busy low.
// An update emits bytes one per cycle starting the cycle after the beat: 3 bytes
// when stopped, else 3 per filled slot with no gap between packets (up to 24);
// the slot memory read overlaps the address byte. busy drops with the last byte.
// Reset is synchronous: all slots empty, stop released. Results cannot be stalled.
module dcc_speed_packet_scheduler_core #(
  parameter int SLOT_COUNT = dsps_pkg::SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [7:0] loco_address,
  input  logic [7:0] speed_step,
  input  logic       forward,
  input  logic       stop_enable,
  output logic       strobe,
  output logic [7:0] packet_byte,
  output logic [2:0] slot_index,
  output logic       last_of_frame,
  output logic       last_of_run
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic                  accept;
  logic [SLOT_COUNT-1:0] valid;
  logic                  stop_flag;
  logic                  in_range;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [7:0]            wr_data;
  logic [7:0]            step_sat;
  logic                  go;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [7:0]            rd_data;

  assign accept   = start && !busy;
  assign in_range = (loco_address != 8'd0) && (32'(loco_address) <= 32'(SLOT_COUNT));
  assign step_sat = (speed_step > dsps_pkg::MAX_STEP) ? dsps_pkg::MAX_STEP : speed_step;
  assign wr_addr  = IDX_W'(loco_address - 8'd1);
  assign wr_data  = (forward ? dsps_pkg::INST_FORWARD : dsps_pkg::INST_REVERSE)
                    | dsps_pkg::step_code(step_sat[4:0]);

  always_comb begin
    wr_en = 1'b0;
    go    = 1'b0;
    unique case (dsps_pkg::func_t'(func))
      dsps_pkg::FUNC_SET_SPEED: wr_en = accept && in_range;
      dsps_pkg::FUNC_STOP_CTRL: ;
      dsps_pkg::FUNC_UPDATE:    go = accept;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      stop_flag <= 1'b0;
    end else if (accept && (func == dsps_pkg::FUNC_STOP_CTRL)) begin
      stop_flag <= stop_enable;
      if (stop_enable) begin
        valid <= '0;
      end
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  dsps_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dsps_emitter #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .stopped       (stop_flag),
    .valid         (valid),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .busy          (busy),
    .strobe        (strobe),
    .packet_byte   (packet_byte),
    .slot_index    (slot_index),
    .last_of_frame (last_of_frame),
    .last_of_run   (last_of_run)
  );

  a_run_ends_frame: assert property (@(posedge clk) disable iff (rst)
    strobe && last_of_run |-> last_of_frame)
    else $error("last byte of run does not close a packet");

  a_frame_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_of_frame |=> strobe)
    else $error("gap inside a packet");

  a_quiet_after_run: assert property (@(posedge clk) disable iff (rst)
    strobe && last_of_run && !accept |=> !strobe)
    else $error("byte emitted after end of run");

  a_idle_on_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last_of_run |-> !busy)
    else $error("still busy on last byte of run");

endmodule

/* test/dcc_speed_packet_scheduler_core_test.sv */
`timescale 1ns / 1ps
module dcc_speed_packet_scheduler_core_test;

  localparam int SLOTS = dsps_pkg::SLOT_COUNT_DEF;
  localparam int CYCLE_CAP = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_COMMANDS = 450;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [7:0] BROADCAST_ADDR = 8'h00;

  typedef struct {
    logic [1:0] func;
    logic [7:0] loco_address;
    logic [7:0] speed_step;
    logic       forward;
    logic       stop_enable;
    bit         drain;
    bit         steady;
  } command_t;

  typedef struct {
    logic [7:0] packet_byte;
    logic [2:0] slot_index;
    logic       last_of_frame;
    logic       last_of_run;
  } dcc_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] func = 2'd0;
  logic [7:0] loco_address = 8'd0;
  logic [7:0] speed_step = 8'd0;
  logic       forward = 1'b0;
  logic       stop_enable = 1'b0;
  logic       strobe;
  logic [7:0] packet_byte;
  logic [2:0] slot_index;
  logic       last_of_frame;
  logic       last_of_run;

  command_t  command_q[$];
  dcc_byte_t packet_q[$];
  bit        packets_drained = 1'b1;
  int        mismatches = 0;
  int        cycle_count = 0;

  bit         slot_used[SLOTS];
  logic [7:0] slot_inst[SLOTS];
  bit         estop;

  dcc_speed_packet_scheduler_core #(
    .SLOT_COUNT(SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .loco_address(loco_address),
    .speed_step(speed_step),
    .forward(forward),
    .stop_enable(stop_enable),
    .strobe(strobe),
    .packet_byte(packet_byte),
    .slot_index(slot_index),
    .last_of_frame(last_of_frame),
    .last_of_run(last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // 28-step code: even steps set bit 4, the rest counts up every two steps
  function automatic logic [7:0] speed_code(input logic [7:0] s);
    logic [7:0] lim;
    lim = (s > dsps_pkg::MAX_STEP) ? dsps_pkg::MAX_STEP : s;
    if (lim == 8'd0) return 8'h00;
    return ((lim + 8'd3) >> 1) | (lim[0] ? 8'h00 : 8'h10);
  endfunction

  task automatic push_packet_byte(input logic [7:0] b, input logic [2:0] slot,
                                  input logic eof, input logic eor);
    dcc_byte_t item;
    item.packet_byte = b;
    item.slot_index = slot;
    item.last_of_frame = eof;
    item.last_of_run = eor;
    packet_q.push_back(item);
  endtask

  task automatic schedule_command(input logic [1:0] f, input logic [7:0] a,
                                  input logic [7:0] s, input logic fw,
                                  input logic en);
    int left;
    logic [7:0] addr_byte;
    case (f)
      dsps_pkg::FUNC_SET_SPEED: begin
        if (a >= 8'd1 && a <= SLOTS) begin
          slot_used[a - 1] = 1'b1;
          slot_inst[a - 1] = (fw ? dsps_pkg::INST_FORWARD : dsps_pkg::INST_REVERSE)
                             | speed_code(s);
        end
      end
      dsps_pkg::FUNC_STOP_CTRL: begin
        estop = en;
        if (en) begin
          for (int k = 0; k < SLOTS; k++) slot_used[k] = 1'b0;
        end
      end
      dsps_pkg::FUNC_UPDATE: begin
        if (estop) begin
          push_packet_byte(BROADCAST_ADDR, 3'd0, 1'b0, 1'b0);
          push_packet_byte(dsps_pkg::STOP_INST, 3'd0, 1'b0, 1'b0);
          push_packet_byte(dsps_pkg::STOP_INST, 3'd0, 1'b1, 1'b1);
        end else begin
          left = 0;
          for (int k = 0; k < SLOTS; k++) if (slot_used[k]) left++;
          for (int k = 0; k < SLOTS; k++) begin
            if (slot_used[k]) begin
              left--;
              addr_byte = 8'(k + 1) & dsps_pkg::ADDR_MASK;
              push_packet_byte(addr_byte, k[2:0], 1'b0, 1'b0);
              push_packet_byte(slot_inst[k], k[2:0], 1'b0, 1'b0);
              push_packet_byte(addr_byte ^ slot_inst[k], k[2:0], 1'b1, left == 0);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_packet_byte();
    dcc_byte_t want;
    if (packet_q.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h slot %0d", packet_byte, slot_index));
    end else begin
      want = packet_q.pop_front();
      if (packet_byte !== want.packet_byte)
        report_mismatch($sformatf("packet_byte %02h, want %02h",
                                  packet_byte, want.packet_byte));
      if (slot_index !== want.slot_index)
        report_mismatch($sformatf("slot_index %0d, want %0d",
                                  slot_index, want.slot_index));
      if (last_of_frame !== want.last_of_frame)
        report_mismatch($sformatf("last_of_frame %0b, want %0b",
                                  last_of_frame, want.last_of_frame));
      if (last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %0b, want %0b",
                                  last_of_run, want.last_of_run));
    end
  endtask

  // check the byte on the ports first, then predict the command taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) begin
        slot_used[k] = 1'b0;
        slot_inst[k] = 8'h00;
      end
      estop = 1'b0;
      packets_drained <= 1'b1;
    end else begin
      if (strobe) check_packet_byte();
      if (start && !busy)
        schedule_command(func, loco_address, speed_step, forward, stop_enable);
      packets_drained <= (packet_q.size() == 0);
    end
  end

  always @(posedge clk) begin : drive
    bit taken;
    bit present;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) void'(command_q.pop_front());
      present = 1'b0;
      if (start && !taken) begin
        present = 1'b1;
      end else if (command_q.size() != 0) begin
        // a drain beat waits until the last predicted byte has been seen
        if (command_q[0].drain)
          present = !taken && packets_drained;
        else
          present = command_q[0].steady || ($urandom_range(0, 99) >= 17);
      end
      if (!present) begin
        start <= 1'b0;
        func <= 2'($urandom);
        loco_address <= 8'($urandom);
        speed_step <= 8'($urandom);
        forward <= 1'($urandom);
        stop_enable <= 1'($urandom);
      end else if (!start || taken) begin
        start <= 1'b1;
        func <= command_q[0].func;
        loco_address <= command_q[0].loco_address;
        speed_step <= command_q[0].speed_step;
        forward <= command_q[0].forward;
        stop_enable <= command_q[0].stop_enable;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_command(input logic [1:0] f, input logic [7:0] a,
                             input logic [7:0] s, input logic fw, input logic en,
                             input bit drain, input bit steady);
    command_t c;
    c.func = f;
    c.loco_address = a;
    c.speed_step = s;
    c.forward = fw;
    c.stop_enable = en;
    c.drain = drain;
    c.steady = steady;
    command_q.push_back(c);
  endtask

  initial begin
    int pick;
    logic [1:0] f;
    logic [7:0] a;
    logic [7:0] s;
    logic fw;
    logic en;

    // empty table, out-of-range addresses and the spare selector
    add_command(dsps_pkg::FUNC_UPDATE, 8'd0, 8'd0, 1'b0, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_SET_SPEED, 8'd0, 8'd5, 1'b1, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_SET_SPEED, 8'd9, 8'd5, 1'b1, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_SET_SPEED, 8'd255, 8'd28, 1'b0, 1'b1, 0, 0);
    add_command(FUNC_SPARE, 8'd1, 8'd3, 1'b1, 1'b1, 0, 0);
    add_command(dsps_pkg::FUNC_UPDATE, 8'd255, 8'd255, 1'b1, 1'b1, 0, 0);
    // step extremes and saturation, both directions
    add_command(dsps_pkg::FUNC_SET_SPEED, 8'd1, 8'd0, 1'b1, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_SET_SPEED, 8'd8, 8'd28, 1'b0, 1'b1, 0, 0);
    add_command(dsps_pkg::FUNC_SET_SPEED, 8'd2, 8'd255, 1'b1, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_SET_SPEED, 8'd3, 8'd29, 1'b0, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_SET_SPEED, 8'd4, 8'd1, 1'b1, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_SET_SPEED, 8'd5, 8'd14, 1'b0, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_UPDATE, 8'd0, 8'd0, 1'b0, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_SET_SPEED, 8'd1, 8'd27, 1'b0, 1'b0, 1, 0);
    add_command(dsps_pkg::FUNC_UPDATE, 8'd0, 8'd0, 1'b0, 1'b0, 0, 0);
    // stop clears the table; a slot written while stopped survives the release
    add_command(dsps_pkg::FUNC_STOP_CTRL, 8'd0, 8'd0, 1'b0, 1'b1, 0, 0);
    add_command(dsps_pkg::FUNC_SET_SPEED, 8'd6, 8'd10, 1'b1, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_UPDATE, 8'd0, 8'd0, 1'b0, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_STOP_CTRL, 8'd0, 8'd0, 1'b0, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_UPDATE, 8'd0, 8'd0, 1'b0, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_STOP_CTRL, 8'd0, 8'd0, 1'b1, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_STOP_CTRL, 8'd0, 8'd0, 1'b0, 1'b1, 0, 0);
    add_command(dsps_pkg::FUNC_STOP_CTRL, 8'd0, 8'd0, 1'b0, 1'b1, 0, 0);
    add_command(dsps_pkg::FUNC_UPDATE, 8'd0, 8'd0, 1'b0, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_STOP_CTRL, 8'd0, 8'd0, 1'b0, 1'b0, 0, 0);
    add_command(dsps_pkg::FUNC_UPDATE, 8'd0, 8'd0, 1'b0, 1'b0, 0, 0);

    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      pick = $urandom_range(0, 99);
      f = 2'($urandom);
      a = 8'($urandom);
      s = 8'($urandom);
      fw = 1'($urandom);
      en = 1'($urandom);
      if (pick < 45) begin
        f = dsps_pkg::FUNC_SET_SPEED;
        a = 8'($urandom_range(1, SLOTS));
        if ($urandom_range(0, 3) != 0) s = 8'($urandom_range(0, 28));
      end else if (pick < 52) begin
        f = dsps_pkg::FUNC_SET_SPEED;
      end else if (pick < 58) begin
        f = dsps_pkg::FUNC_STOP_CTRL;
        en = ($urandom_range(0, 2) == 0);
      end else if (pick < 92) begin
        f = dsps_pkg::FUNC_UPDATE;
      end else begin
        f = FUNC_SPARE;
      end
      add_command(f, a, s, fw, en, (n % 150) == 75, n >= 200 && n < 300);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (command_q.size() != 0 || start || packet_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* dcc_speed_packet_scheduler_core.f */
rtl/dsps_pkg.sv
rtl/dsps_slot_ram.sv
rtl/dsps_emitter.sv
rtl/dcc_speed_packet_scheduler_core.sv
test/dcc_speed_packet_scheduler_core_test.sv
